### design/slsc_pkg.sv
// ----------------------------------------------------------------------------
// Status line classifier package
// Types, character codes and header prefixes shared by the classifier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slsc_pkg;

   // Character codes used by the line parser.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_NL    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_QUERY = 8'h3f;
   localparam logic [7:0] CHAR_U     = 8'h75;

   // Header prefixes: "# branch.ab +" and "# stash ".
   localparam int BRANCH_LEN = 13;
   localparam int STASH_LEN  = 8;

   localparam logic [7:0] BRANCH_PFX [0:BRANCH_LEN-1] = '{
      8'h23, 8'h20, 8'h62, 8'h72, 8'h61, 8'h6e, 8'h63,
      8'h68, 8'h2e, 8'h61, 8'h62, 8'h20, 8'h2b
   };

   localparam logic [7:0] STASH_PFX [0:STASH_LEN-1] = '{
      8'h23, 8'h20, 8'h73, 8'h74, 8'h61, 8'h73, 8'h68, 8'h20
   };

   // Count values saturate at this bound.
   localparam logic [15:0] COUNT_MAX = 16'hffff;

   // Phases of the decimal number parser.
   localparam logic [1:0] NUM_SKIP   = 2'd0;
   localparam logic [1:0] NUM_DIGITS = 2'd1;
   localparam logic [1:0] NUM_DONE   = 2'd2;

   // State of one decimal number parser.
   typedef struct packed {
      logic [1:0]  phase;
      logic        neg;
      logic [15:0] acc;
   } num_state_type;

   // Accumulated status marks.
   typedef struct packed {
      logic untracked;
      logic unmerged;
      logic unstaged;
      logic staged;
   } marks_type;

endpackage

`default_nettype wire

### design/status_line_stream_classifier.sv
// ----------------------------------------------------------------------------
// Status line stream classifier
// A result is registered from its newline beat and shows in the cycle after that beat is accepted.
// Throughput: one byte per cycle while req_stall is low; the line state is updated
// in the cycle of the beat, so consecutive bytes need no gaps.
// The input stalls only while a result is held and the output is stalled.
// Synchronous reset clears marks, counts, line state and the mode register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module status_line_stream_classifier #(
   parameter int LINE_MAX = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_byte_req,
   // Result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_staged,
   output      logic        rsp_unstaged,
   output      logic        rsp_unmerged,
   output      logic        rsp_untracked,
   output      logic [15:0] rsp_ahead_count,
   output      logic [15:0] rsp_behind_count,
   output      logic [15:0] rsp_stash_count,
   output      logic        rsp_all_found,
   // Configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   localparam int POS_W = $clog2(LINE_MAX);
   localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(LINE_MAX - 1);
   localparam logic [POS_W-1:0] POS_BRANCH = POS_W'(slsc_pkg::BRANCH_LEN);
   localparam logic [POS_W-1:0] POS_STASH  = POS_W'(slsc_pkg::STASH_LEN);

   // Line state.
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    ended_ff, ended_in;
   logic [7:0]              c0_ff, c0_in;
   logic [7:0]              c1_ff, c1_in;
   logic                    x_changed_ff, x_changed_in;
   logic                    y_changed_ff, y_changed_in;
   logic                    branch_match_ff, branch_match_in;
   logic                    stash_match_ff, stash_match_in;
   logic                    dash_ff, dash_in;
   slsc_pkg::num_state_type num1_ff, num1_in, num1_step;
   slsc_pkg::num_state_type num2_ff, num2_in, num2_step;

   // Accumulated status.
   slsc_pkg::marks_type     marks_ff, marks_in;
   logic [15:0]             ahead_ff, ahead_in;
   logic [15:0]             behind_ff, behind_in;
   logic [15:0]             stash_ff, stash_in;
   logic                    count_untracked_ff;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   slsc_pkg::marks_type     rsp_marks_ff;
   logic [15:0]             rsp_ahead_ff, rsp_behind_ff, rsp_stash_ff;
   logic                    rsp_all_found_ff;

   logic                    req_accept;
   logic                    is_newline;
   logic                    emit;
   logic                    all_found_in;
   logic                    branch_miss;
   logic                    stash_miss;
   logic                    in_branch_body;
   logic                    in_stash_body;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign is_newline = (req_byte_req == slsc_pkg::CHAR_NL);
   assign emit       = req_accept & ~req_kind & is_newline;

   // Header prefix comparison at the current position.
   always_comb begin
      branch_miss = 1'b0;
      stash_miss  = 1'b0;
      if (pos_ff < POS_BRANCH) begin
         branch_miss = (req_byte_req != slsc_pkg::BRANCH_PFX[pos_ff[3:0]]);
      end
      if (pos_ff < POS_STASH) begin
         stash_miss = (req_byte_req != slsc_pkg::STASH_PFX[pos_ff[2:0]]);
      end
   end

   assign in_branch_body = (pos_ff >= POS_BRANCH) & branch_match_ff;
   assign in_stash_body  = (pos_ff >= POS_STASH) & stash_match_ff;

   // Number parsers for the first and the second header number.
   slsc_num_step u_num1 (
      .byte_in (req_byte_req),
      .cur     (num1_ff),
      .nxt     (num1_step)
   );

   slsc_num_step u_num2 (
      .byte_in (req_byte_req),
      .cur     (num2_ff),
      .nxt     (num2_step)
   );

   // Next-state logic for one accepted beat.
   always_comb begin
      pos_in          = pos_ff;
      ended_in        = ended_ff;
      c0_in           = c0_ff;
      c1_in           = c1_ff;
      x_changed_in    = x_changed_ff;
      y_changed_in    = y_changed_ff;
      branch_match_in = branch_match_ff;
      stash_match_in  = stash_match_ff;
      dash_in         = dash_ff;
      num1_in         = num1_ff;
      num2_in         = num2_ff;
      marks_in        = marks_ff;
      ahead_in        = ahead_ff;
      behind_in       = behind_ff;
      stash_in        = stash_ff;

      if (req_kind) begin
         // Clear beat: start a new scan.
         marks_in  = '0;
         ahead_in  = '0;
         behind_in = '0;
         stash_in  = '0;
      end else if (is_newline) begin
         // Classify the finished line.
         if (pos_ff != '0) begin
            if (c0_ff == slsc_pkg::CHAR_HASH) begin
               if (branch_match_ff && pos_ff >= POS_BRANCH) begin
                  ahead_in = num1_ff.neg ? 16'd0 : num1_ff.acc;
                  if (dash_ff) begin
                     behind_in = num2_ff.neg ? 16'd0 : num2_ff.acc;
                  end
               end else if (stash_match_ff && pos_ff >= POS_STASH) begin
                  stash_in = num1_ff.neg ? 16'd0 : num1_ff.acc;
               end
            end else if ((c0_ff == slsc_pkg::CHAR_ONE || c0_ff == slsc_pkg::CHAR_TWO) &&
                         c1_ff == slsc_pkg::CHAR_SPACE && pos_ff >= POS_W'(4)) begin
               marks_in.staged   = marks_ff.staged | x_changed_ff;
               marks_in.unstaged = marks_ff.unstaged | y_changed_ff;
            end else if (c0_ff == slsc_pkg::CHAR_U && c1_ff == slsc_pkg::CHAR_SPACE &&
                         pos_ff >= POS_W'(2)) begin
               marks_in.staged   = 1'b1;
               marks_in.unstaged = 1'b1;
               marks_in.unmerged = 1'b1;
            end else if (c0_ff == slsc_pkg::CHAR_QUERY && c1_ff == slsc_pkg::CHAR_SPACE &&
                         pos_ff >= POS_W'(2)) begin
               marks_in.untracked = 1'b1;
            end
         end
      end else if (~ended_ff && pos_ff < POS_LIMIT) begin
         if (req_byte_req == slsc_pkg::CHAR_NUL) begin
            ended_in = 1'b1;
         end else begin
            // Absorb one text byte.
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff == POS_W'(0)) begin
               c0_in = req_byte_req;
            end
            if (pos_ff == POS_W'(1)) begin
               c1_in = req_byte_req;
            end
            if (pos_ff == POS_W'(2)) begin
               x_changed_in = (req_byte_req != slsc_pkg::CHAR_DOT);
            end
            if (pos_ff == POS_W'(3)) begin
               y_changed_in = (req_byte_req != slsc_pkg::CHAR_DOT);
            end
            if (branch_miss) begin
               branch_match_in = 1'b0;
            end
            if (stash_miss) begin
               stash_match_in = 1'b0;
            end
            if (in_branch_body || in_stash_body) begin
               num1_in = num1_step;
            end
            if (in_branch_body) begin
               if (!dash_ff) begin
                  dash_in = (req_byte_req == slsc_pkg::CHAR_MINUS);
               end else begin
                  num2_in = num2_step;
               end
            end
         end
      end

      // A newline or a clear beat also starts a fresh line.
      if (req_kind || is_newline) begin
         pos_in          = '0;
         ended_in        = 1'b0;
         c0_in           = '0;
         c1_in           = '0;
         x_changed_in    = 1'b0;
         y_changed_in    = 1'b0;
         branch_match_in = 1'b1;
         stash_match_in  = 1'b1;
         dash_in         = 1'b0;
         num1_in         = '0;
         num2_in         = '0;
      end
   end

   // All wanted marks set.
   assign all_found_in = marks_in.staged & marks_in.unstaged & marks_in.unmerged &
                         (marks_in.untracked | ~count_untracked_ff);

   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   // Control and line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff             <= '0;
         ended_ff           <= 1'b0;
         c0_ff              <= '0;
         c1_ff              <= '0;
         x_changed_ff       <= 1'b0;
         y_changed_ff       <= 1'b0;
         branch_match_ff    <= 1'b1;
         stash_match_ff     <= 1'b1;
         dash_ff            <= 1'b0;
         num1_ff            <= '0;
         num2_ff            <= '0;
         marks_ff           <= '0;
         ahead_ff           <= '0;
         behind_ff          <= '0;
         stash_ff           <= '0;
         count_untracked_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            pos_ff          <= pos_in;
            ended_ff        <= ended_in;
            c0_ff           <= c0_in;
            c1_ff           <= c1_in;
            x_changed_ff    <= x_changed_in;
            y_changed_ff    <= y_changed_in;
            branch_match_ff <= branch_match_in;
            stash_match_ff  <= stash_match_in;
            dash_ff         <= dash_in;
            num1_ff         <= num1_in;
            num2_ff         <= num2_in;
            marks_ff        <= marks_in;
            ahead_ff        <= ahead_in;
            behind_ff       <= behind_in;
            stash_ff        <= stash_in;
         end
         if (csr_wr_en) begin
            count_untracked_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register, loaded with each emitted beat.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_marks_ff     <= marks_in;
         rsp_ahead_ff     <= ahead_in;
         rsp_behind_ff    <= behind_in;
         rsp_stash_ff     <= stash_in;
         rsp_all_found_ff <= all_found_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_staged       = rsp_marks_ff.staged;
   assign rsp_unstaged     = rsp_marks_ff.unstaged;
   assign rsp_unmerged     = rsp_marks_ff.unmerged;
   assign rsp_untracked    = rsp_marks_ff.untracked;
   assign rsp_ahead_count  = rsp_ahead_ff;
   assign rsp_behind_count = rsp_behind_ff;
   assign rsp_stash_count  = rsp_stash_ff;
   assign rsp_all_found    = rsp_all_found_ff;

`ifndef SYNTHESIS
   // The line position never runs past the counted part of a line.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("line position beyond limit");

   // A clear beat empties marks and counts.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind |=> marks_ff == '0 && ahead_ff == '0 &&
                                 behind_ff == '0 && stash_ff == '0)
      else $error("clear beat left status behind");

   // A newline beat always produces a result in the next cycle.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && pos_ff == '0)
      else $error("newline beat produced no result");

   // The all-found flag never shows without the three tracked marks.
   a_all_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_found |-> rsp_staged && rsp_unstaged && rsp_unmerged)
      else $error("all-found flag without its marks");
`endif

endmodule

`default_nettype wire

### design/slsc_num_step.sv
// ----------------------------------------------------------------------------
// Decimal number parser step
// Advances one decimal number parser by one byte: leading white space is
// skipped, one sign is taken, then digits accumulate with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slsc_num_step (
   input  wire logic [7:0]             byte_in,
   input  wire slsc_pkg::num_state_type cur,
   output      slsc_pkg::num_state_type nxt
);

   logic        is_digit;
   logic        is_blank;
   logic [19:0] times_ten;
   logic [19:0] acc_sum;
   logic [15:0] acc_sat;

   // Character classes.
   always_comb begin
      is_digit = byte_in inside {[slsc_pkg::CHAR_ZERO:slsc_pkg::CHAR_NINE]};
      is_blank = (byte_in == slsc_pkg::CHAR_SPACE) ||
                 (byte_in inside {[slsc_pkg::CHAR_TAB:slsc_pkg::CHAR_CR]});
   end

   // Accumulate one digit: acc * 10 + digit, saturating at the count maximum.
   always_comb begin
      times_ten = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0};
      acc_sum   = times_ten + {16'd0, byte_in[3:0]};
      acc_sat   = (acc_sum > {4'd0, slsc_pkg::COUNT_MAX}) ? slsc_pkg::COUNT_MAX
                                                          : acc_sum[15:0];
   end

   // Phase update.
   always_comb begin
      nxt = cur;
      case (cur.phase)
         slsc_pkg::NUM_SKIP: begin
            if (is_blank) begin
               nxt = cur;
            end else if (byte_in == slsc_pkg::CHAR_PLUS) begin
               nxt.phase = slsc_pkg::NUM_DIGITS;
            end else if (byte_in == slsc_pkg::CHAR_MINUS) begin
               nxt.phase = slsc_pkg::NUM_DIGITS;
               nxt.neg   = 1'b1;
            end else if (is_digit) begin
               nxt.phase = slsc_pkg::NUM_DIGITS;
               nxt.acc   = acc_sat;
            end else begin
               nxt.phase = slsc_pkg::NUM_DONE;
            end
         end
         slsc_pkg::NUM_DIGITS: begin
            if (is_digit) begin
               nxt.acc = acc_sat;
            end else begin
               nxt.phase = slsc_pkg::NUM_DONE;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

### tb/status_line_classifier_checker.sv
// ----------------------------------------------------------------------------
// Status line classifier checker
// Watches the byte and result channels of the classifier, keeps its own
// model of the line parser, the marks and the counts, and compares every
// result beat field by field with the oldest predicted status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module status_line_classifier_checker #(
   parameter int LINE_MAX = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_byte_req,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_staged,
   input  wire logic        rsp_unstaged,
   input  wire logic        rsp_unmerged,
   input  wire logic        rsp_untracked,
   input  wire logic [15:0] rsp_ahead_count,
   input  wire logic [15:0] rsp_behind_count,
   input  wire logic [15:0] rsp_stash_count,
   input  wire logic        rsp_all_found,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   output int               error_count,
   output int               pending_results
);

   localparam int POS_W = $clog2(LINE_MAX);

   // One predicted status beat.
   typedef struct packed {
      slsc_pkg::marks_type marks;
      logic [15:0]         ahead;
      logic [15:0]         behind;
      logic [15:0]         stash;
      logic                all_found;
   } status_beat_type;

   status_beat_type status_q[$];
   status_beat_type want_beat;
   int              mismatches;

   // Model of the mode register and of the line parser.
   logic                    need_untracked;
   logic [POS_W-1:0]        line_pos;
   logic                    line_cut;
   logic [15:0]             lead_chars;
   logic [3:0]              col_flags;
   logic [1:0]              hdr_match;
   slsc_pkg::num_state_type first_num;
   slsc_pkg::num_state_type second_num;
   logic                    dash_seen;
   slsc_pkg::marks_type     marks;
   logic [15:0]             ahead;
   logic [15:0]             behind;
   logic [15:0]             stash;

   // One byte through a decimal conversion: blanks, one sign, then digits.
   function automatic slsc_pkg::num_state_type next_number_state(
      input slsc_pkg::num_state_type s, input logic [7:0] b);
      logic is_digit;
      int   v;
      is_digit = (b >= slsc_pkg::CHAR_ZERO) && (b <= slsc_pkg::CHAR_NINE);
      if (s.phase == slsc_pkg::NUM_SKIP) begin
         if (b == slsc_pkg::CHAR_SPACE ||
             (b >= slsc_pkg::CHAR_TAB && b <= slsc_pkg::CHAR_CR))
            return s;
         if (b == slsc_pkg::CHAR_PLUS) begin
            s.phase = slsc_pkg::NUM_DIGITS;
            return s;
         end
         if (b == slsc_pkg::CHAR_MINUS) begin
            s.neg   = 1'b1;
            s.phase = slsc_pkg::NUM_DIGITS;
            return s;
         end
         s.phase = is_digit ? slsc_pkg::NUM_DIGITS : slsc_pkg::NUM_DONE;
      end else if (s.phase == slsc_pkg::NUM_DIGITS) begin
         if (!is_digit)
            s.phase = slsc_pkg::NUM_DONE;
      end
      if (s.phase == slsc_pkg::NUM_DIGITS && is_digit) begin
         v = int'(s.acc) * 10 + int'(b - slsc_pkg::CHAR_ZERO);
         s.acc = (v > int'(slsc_pkg::COUNT_MAX)) ? slsc_pkg::COUNT_MAX : 16'(v);
      end
      return s;
   endfunction

   task automatic clear_line_state();
      line_pos   = '0;
      line_cut   = 1'b0;
      lead_chars = '0;
      col_flags  = '0;
      hdr_match  = 2'b11;
      first_num  = '0;
      second_num = '0;
      dash_seen  = 1'b0;
   endtask

   task automatic clear_status();
      marks  = '0;
      ahead  = '0;
      behind = '0;
      stash  = '0;
      clear_line_state();
   endtask

   // Fold one counted byte of the line into the parser state.
   task automatic absorb_byte(input logic [7:0] b);
      if (line_pos == 0)
         lead_chars[7:0] = b;
      else if (line_pos == 1)
         lead_chars[15:8] = b;
      else if (line_pos == 2)
         col_flags = col_flags | {2'b00, b != slsc_pkg::CHAR_DOT, 1'b1};
      else if (line_pos == 3)
         col_flags = col_flags | {b != slsc_pkg::CHAR_DOT, 1'b1, 2'b00};
      if (line_pos < slsc_pkg::BRANCH_LEN) begin
         if (b != slsc_pkg::BRANCH_PFX[line_pos[3:0]])
            hdr_match[0] = 1'b0;
      end
      if (line_pos < slsc_pkg::STASH_LEN) begin
         if (b != slsc_pkg::STASH_PFX[line_pos[2:0]])
            hdr_match[1] = 1'b0;
      end
      if ((line_pos >= slsc_pkg::BRANCH_LEN && hdr_match[0]) ||
          (line_pos >= slsc_pkg::STASH_LEN && hdr_match[1]))
         first_num = next_number_state(first_num, b);
      if (line_pos >= slsc_pkg::BRANCH_LEN && hdr_match[0]) begin
         if (!dash_seen)
            dash_seen = (b == slsc_pkg::CHAR_MINUS);
         else
            second_num = next_number_state(second_num, b);
      end
   endtask

   // Apply a finished line to the marks and the counts.
   task automatic classify_line();
      logic [7:0] c0;
      logic [7:0] c1;
      c0 = lead_chars[7:0];
      c1 = lead_chars[15:8];
      if (line_pos != 0) begin
         if (c0 == slsc_pkg::CHAR_HASH) begin
            if (hdr_match[0] && line_pos >= slsc_pkg::BRANCH_LEN) begin
               ahead = first_num.neg ? 16'd0 : first_num.acc;
               if (dash_seen)
                  behind = second_num.neg ? 16'd0 : second_num.acc;
            end else if (hdr_match[1] && line_pos >= slsc_pkg::STASH_LEN) begin
               stash = first_num.neg ? 16'd0 : first_num.acc;
            end
         end else if ((c0 == slsc_pkg::CHAR_ONE || c0 == slsc_pkg::CHAR_TWO) &&
                      c1 == slsc_pkg::CHAR_SPACE && line_pos >= 4) begin
            if (col_flags[1])
               marks.staged = 1'b1;
            if (col_flags[3])
               marks.unstaged = 1'b1;
         end else if (c0 == slsc_pkg::CHAR_U && c1 == slsc_pkg::CHAR_SPACE &&
                      line_pos >= 2) begin
            marks.staged   = 1'b1;
            marks.unstaged = 1'b1;
            marks.unmerged = 1'b1;
         end else if (c0 == slsc_pkg::CHAR_QUERY && c1 == slsc_pkg::CHAR_SPACE &&
                      line_pos >= 2) begin
            marks.untracked = 1'b1;
         end
      end
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         need_untracked = 1'b0;
         clear_status();
         status_q.delete();
         mismatches = 0;
      end else begin
         // Result beat against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: result beat expected none actual ahead %0d behind %0d",
                        $time, rsp_ahead_count, rsp_behind_count);
            end else begin
               want_beat = status_q.pop_front();
               check_field("staged", want_beat.marks.staged, rsp_staged);
               check_field("unstaged", want_beat.marks.unstaged, rsp_unstaged);
               check_field("unmerged", want_beat.marks.unmerged, rsp_unmerged);
               check_field("untracked", want_beat.marks.untracked, rsp_untracked);
               check_field("ahead_count", want_beat.ahead, rsp_ahead_count);
               check_field("behind_count", want_beat.behind, rsp_behind_count);
               check_field("stash_count", want_beat.stash, rsp_stash_count);
               check_field("all_found", want_beat.all_found, rsp_all_found);
            end
         end

         if (csr_wr_en)
            need_untracked = csr_wr_data;

         // Byte beat: clear, counted byte, or end of line.
         if (req_valid && !req_stall) begin
            if (req_kind) begin
               clear_status();
            end else if (req_byte_req != slsc_pkg::CHAR_NL) begin
               if (!line_cut && line_pos < LINE_MAX - 1) begin
                  if (req_byte_req == slsc_pkg::CHAR_NUL) begin
                     line_cut = 1'b1;
                  end else begin
                     absorb_byte(req_byte_req);
                     line_pos++;
                  end
               end
            end else begin
               classify_line();
               clear_line_state();
               want_beat.marks     = marks;
               want_beat.ahead     = ahead;
               want_beat.behind    = behind;
               want_beat.stash     = stash;
               want_beat.all_found = marks.staged && marks.unstaged && marks.unmerged &&
                                     (!need_untracked || marks.untracked);
               status_q.push_back(want_beat);
            end
         end
      end
      pending_results <= status_q.size();
      error_count     <= mismatches;
   end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Status line stream classifier testbench
// Feeds status listings byte by byte: a short directed set of lines, then
// random change, unmerged, untracked, header, noise and clear items, with
// random idling on both channels. The checker predicts every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int         HOLD_CYCLES   = 200;
   localparam int         SETTLE_CYCLES = 4;
   localparam logic [7:0] CHAR_VTAB     = 8'h0b;
   localparam logic [7:0] CHAR_FEED     = 8'h0c;
   localparam logic [7:0] BLANKS [0:4]  = '{slsc_pkg::CHAR_TAB, CHAR_VTAB, CHAR_FEED,
                                            slsc_pkg::CHAR_CR, slsc_pkg::CHAR_SPACE};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_byte_req;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_staged;
   logic        rsp_unstaged;
   logic        rsp_unmerged;
   logic        rsp_untracked;
   logic [15:0] rsp_ahead_count;
   logic [15:0] rsp_behind_count;
   logic [15:0] rsp_stash_count;
   logic        rsp_all_found;
   logic        csr_wr_en;
   logic        csr_wr_data;

   int          error_count;
   int          pending_results;
   int          beats_sent;
   bit          req_burst;
   bit          rsp_burst;
   bit          hold_request;
   logic [7:0]  line_text[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   status_line_stream_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_byte_req     (req_byte_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_staged       (rsp_staged),
      .rsp_unstaged     (rsp_unstaged),
      .rsp_unmerged     (rsp_unmerged),
      .rsp_untracked    (rsp_untracked),
      .rsp_ahead_count  (rsp_ahead_count),
      .rsp_behind_count (rsp_behind_count),
      .rsp_stash_count  (rsp_stash_count),
      .rsp_all_found    (rsp_all_found),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   status_line_classifier_checker status_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_byte_req     (req_byte_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_staged       (rsp_staged),
      .rsp_unstaged     (rsp_unstaged),
      .rsp_unmerged     (rsp_unmerged),
      .rsp_untracked    (rsp_untracked),
      .rsp_ahead_count  (rsp_ahead_count),
      .rsp_behind_count (rsp_behind_count),
      .rsp_stash_count  (rsp_stash_count),
      .rsp_all_found    (rsp_all_found),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (error_count),
      .pending_results  (pending_results)
   );

   // Offer one beat after a random gap and wait until it is taken.
   task automatic send_beat(input logic kind, input logic [7:0] b);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_byte_req <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
   endtask

   // Stop offering and let every predicted result come out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic count_untracked);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count_untracked;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_text.push_back(s[i]);
   endtask

   // A decimal field as a header might carry it, sometimes malformed.
   task automatic push_number();
      int style;
      int sign;
      int run;
      if ($urandom_range(0, 3) == 0)
         line_text.push_back(BLANKS[$urandom_range(0, 4)]);
      sign = $urandom_range(0, 7);
      if (sign == 0)
         line_text.push_back(slsc_pkg::CHAR_PLUS);
      else if (sign == 1)
         line_text.push_back(slsc_pkg::CHAR_MINUS);
      style = $urandom_range(0, 5);
      if (style <= 2) begin
         push_text($sformatf("%0d", $urandom_range(0, 30)));
      end else if (style == 3) begin
         push_text($sformatf("%0d", $urandom_range(0, 99999)));
      end else if (style == 4) begin
         push_text($sformatf("%0d", $urandom_range(65530, 65540)));
      end else begin
         run = $urandom_range(6, 12);
         repeat (run)
            line_text.push_back(slsc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   // Send the built line with its newline; random lines may be cut short,
   // have one byte corrupted or carry a zero byte.
   task automatic send_line(input bit exact);
      int cut;
      if (!exact) begin
         if (line_text.size() > 0 && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, line_text.size() - 1);
            while (line_text.size() > cut)
               void'(line_text.pop_back());
         end
         if (line_text.size() > 0 && $urandom_range(0, 9) == 0)
            line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 11) == 0)
            line_text.insert($urandom_range(0, line_text.size()), slsc_pkg::CHAR_NUL);
      end
      line_text.push_back(slsc_pkg::CHAR_NL);
      foreach (line_text[i])
         send_beat(1'b0, line_text[i]);
      line_text.delete();
   endtask

   task automatic random_line();
      int pick;
      int n;
      pick = $urandom_range(0, 23);
      if (pick <= 5) begin
         // Changed or renamed entry with two status columns.
         line_text.push_back($urandom_range(0, 1) ? slsc_pkg::CHAR_ONE :
                                                    slsc_pkg::CHAR_TWO);
         line_text.push_back(slsc_pkg::CHAR_SPACE);
         repeat (2) line_text.push_back($urandom_range(0, 1) ? slsc_pkg::CHAR_DOT :
                                        8'($urandom_range(33, 126)));
         push_text(" N... 100644 src/a.c");
      end else if (pick <= 7) begin
         push_text("u UU N... f.c");
      end else if (pick <= 9) begin
         push_text("? new.txt");
      end else if (pick <= 13 || pick >= 21) begin
         push_text("# branch.ab +");
         push_number();
         if ($urandom_range(0, 3) != 0) begin
            push_text(" -");
            push_number();
         end
      end else if (pick <= 15) begin
         push_text("# stash ");
         push_number();
      end else if (pick == 16) begin
         push_text("# branch.oid 1a2b3c");
      end else if (pick <= 18) begin
         n = $urandom_range(1, 10);
         repeat (n) line_text.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 20) begin
         send_beat(1'b1, 8'($urandom_range(0, 255)));
         return;
      end
      send_line(1'b0);
   endtask

   task automatic random_phase(input int beats);
      int stop;
      stop = beats_sent + beats;
      while (beats_sent < stop) begin
         if ($urandom_range(0, 15) == 0)
            req_burst = !req_burst;
         if ($urandom_range(0, 15) == 0)
            rsp_burst = !rsp_burst;
         random_line();
      end
   endtask

   // Result side: a random stall before each beat, or one long hold-off.
   initial begin : result_sink
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            gap = rsp_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
      end
   end

   initial begin : watchdog
      #1_000_000;
      $display("status_line_stream_classifier: mismatch");
      $finish;
   end

   initial begin : stimulus
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_kind     <= 1'b0;
      req_byte_req <= '0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= 1'b0;
      beats_sent   = 0;
      req_burst    = 1'b0;
      rsp_burst    = 1'b0;
      hold_request = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);

      // Directed lines: each mark, saturation, a negative count, a zero
      // byte ending a line early, a truncated header and a clear.
      push_text("1 M.");
      send_line(1'b1);
      push_text("2 .Z");
      send_line(1'b1);
      push_text("? ");
      send_line(1'b1);
      push_text("u ");
      send_line(1'b1);
      push_text("# stash 99999");
      send_line(1'b1);
      push_text("# branch.ab +7 -3");
      send_line(1'b1);
      send_beat(1'b1, 8'hff);
      push_text("# branch.ab +-2");
      line_text.push_back(slsc_pkg::CHAR_NUL);
      push_text("x");
      send_line(1'b1);
      push_text("# stas");
      send_line(1'b1);
      wait_idle();

      // Untracked required; the result side holds off long enough for the
      // input to back up, and later the sender waits for all results.
      write_mode(1'b1);
      hold_request = 1'b1;
      random_phase(300);
      wait_idle();
      random_phase(300);
      wait_idle();

      // A line past the length limit, whose behind count is cut off.
      write_mode(1'b0);
      push_text("# branch.ab +");
      repeat (236) line_text.push_back(slsc_pkg::CHAR_SPACE);
      push_text("123 -4567");
      send_line(1'b1);
      random_phase(375);
      wait_idle();

      write_mode(1'b1);
      random_phase(375);
      wait_idle();
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("status_line_stream_classifier: match");
      else
         $display("status_line_stream_classifier: mismatch");
      $finish;
   end

endmodule
